// ----- design/assert_macros.svh -----
// assertion helpers included by bbr_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the cycle after ante, ignored while in reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// check that cons holds in the same cycle as ante, ignored while in reset
`define AST_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that cons holds in the cycle after ante, also during reset
`define AST_NEXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/bbr_pkg.sv -----
// ----------------------------------------------------------------------------
// bbr_pkg
// shared types and constants of the reflect-101 box blur
// ----------------------------------------------------------------------------
package bbr_pkg;

  // register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KERNEL_SIZE  = 2'd2;

  // register widths and reset values
  localparam int CFG_DATA_W = 13;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [3:0]  KERNEL_RST = 4'd3;
  localparam int MAX_HEIGHT = 4096;

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       last_of_frame;
  } out_req_t;

endpackage

// ----- design/box_blur_reflect101.sv -----
// ----------------------------------------------------------------------------
// box_blur_reflect101
// k-by-k mean filter over a raster pixel stream with reflect-101 borders
// ----------------------------------------------------------------------------
// Input requests carry a pixel or a flush tick; a request is taken when
// in_valid is high and in_stall low. Results leave through an output
// register on out_valid/out_stall, so a finished mean can wait there while
// the next request is taken. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); a mapped register write restarts the frame.
// Pixels are kept in a line store ram of (MAX_KERNEL+1) rows.
// A request that produces no result leaves the sequencer idle. For a mean,
// the window is summed one pixel a cycle through the single read port of
// the line store, each window row first passes four row address setup
// states, and the rounding divide retires one quotient bit a cycle.
// Only one request is worked on at a time; in_stall is high while a mean is
// being formed. While the receiver stalls, the result stays in the output
// register and a further mean waits before loading it.
// Synchronous reset clears the counters, the output register and the
// configuration to 640 x 480 with k = 3; the line store is not cleared.
// Outputs start k/2+1 rows after the first pixel; flush ticks drain the rest.
module box_blur_reflect101 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bbr_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bbr_pkg::out_req_t             out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbr_pkg::*;

  localparam int SR    = MAX_KERNEL + 1;
  localparam int DEPTH = SR * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SLW   = $clog2(SR);
  localparam int RW    = 13;
  localparam int RYW   = 12;
  localparam int SW    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int NUM_W = SW + 2;
  localparam int DW    = $clog2(2 * MAX_KERNEL * MAX_KERNEL + 1);
  localparam int CNTW  = $clog2(NUM_W + 1);
  localparam int RSH   = 20;
  localparam int RCW   = 21;
  localparam int RECIP = (2 ** RSH + SR - 1) / SR;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROWA = 4'd1;
  localparam logic [3:0] S_ROWB = 4'd2;
  localparam logic [3:0] S_ROWC = 4'd3;
  localparam logic [3:0] S_ROWD = 4'd4;
  localparam logic [3:0] S_TAP  = 4'd5;
  localparam logic [3:0] S_TAIL = 4'd6;
  localparam logic [3:0] S_DSET = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // reflect-101 index mapping
  function automatic logic signed [14:0] mirror(input logic signed [14:0] i,
                                                input logic signed [14:0] n);
    logic signed [14:0] v;
    v = i;
    if (v < 0) v = -v;
    if (v >= n) v = 15'(2 * (n - 15'sd1) - v);
    if (v < 0 || v >= n) v = '0;
    return v;
  endfunction

  logic [10:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [3:0]  kern_r, kern_nxt;
  logic [3:0]  state_r, state_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [SLW-1:0] in_slot_r, in_slot_nxt, slot_r, slot_nxt;
  logic signed [5:0] dy_r, dy_nxt, dx_r, dx_nxt;
  logic [RYW-1:0] ry_r, ry_nxt;
  logic [RYW+RCW-1:0] prod_r, prod_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [NUM_W-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  out_req_t out_data_r, out_data_nxt;

  logic [2:0] half;
  logic [7:0] kk;
  logic [DW-1:0] den;
  logic setup_ok, accept, emit_ok;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] rdata;
  logic signed [14:0] ry_s, cx_s;
  logic [RYW-RSH+RCW-1:0] quot_est;
  logic [RYW:0] rem_est;
  logic [DW:0] rem_sh;

  // setup check
  always_comb begin
    half = kern_r[3:1];
    kk   = {4'd0, kern_r} * {4'd0, kern_r};
    den  = DW'({kk, 1'b0});
    setup_ok = (kern_r != 4'd0) && kern_r[0] && (int'(kern_r) <= MAX_KERNEL) &&
               ({8'd0, half} + 11'd2 <= width_r) && (int'(width_r) <= MAX_WIDTH) &&
               ({10'd0, half} + 13'd2 <= height_r) && (int'(height_r) <= MAX_HEIGHT);
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // line store
  bbr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(in_data.pixel_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  // sequencer and datapath
  always_comb begin
    width_nxt = width_r;  height_nxt = height_r;  kern_nxt = kern_r;
    state_nxt = state_r;
    in_row_nxt = in_row_r;  in_col_nxt = in_col_r;  in_slot_nxt = in_slot_r;
    out_row_nxt = out_row_r;  out_col_nxt = out_col_r;
    slot_nxt = slot_r;  dy_nxt = dy_r;  dx_nxt = dx_r;
    ry_nxt = ry_r;  prod_nxt = prod_r;  base_nxt = base_r;
    sum_nxt = sum_r;  rd_vld_nxt = 1'b0;
    num_nxt = num_r;  quo_nxt = quo_r;  rem_nxt = rem_r;  cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    we = 1'b0;
    waddr = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
    emit_ok = 1'b0;

    ry_s = mirror($signed({2'b00, out_row_r}) + 15'(dy_r), $signed({2'b00, height_r}));
    cx_s = mirror($signed(15'(out_col_r)) + 15'(dx_r), $signed({4'd0, width_r}));
    raddr = base_r + AW'(cx_s);
    quot_est = prod_r[RYW+RCW-1:RSH];
    rem_est = {1'b0, ry_r} - (RYW+1)'(quot_est * SR);
    if (rem_est >= (RYW+1)'(SR)) rem_est = rem_est - (RYW+1)'(SR);
    rem_sh = {rem_r, num_r[NUM_W-1]};

    // window sum accumulates the read that was issued last cycle
    if (rd_vld_r) sum_nxt = sum_r + SW'(rdata);

    case (state_r)
      S_IDLE: begin
        if (accept && setup_ok) begin
          if (in_data.operation == OP_FLUSH) begin
            emit_ok = (in_row_r >= RW'(height_r)) && (out_row_r < RW'(height_r));
          end else if (in_row_r < RW'(height_r)) begin
            we = 1'b1;
            emit_ok = (in_row_r >= RW'(half) + RW'(1));
            if (32'(in_col_r) + 1 >= 32'(width_r)) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + RW'(1);
              in_slot_nxt = (32'(in_slot_r) == SR - 1) ? '0 : in_slot_r + SLW'(1);
            end else begin
              in_col_nxt = in_col_r + CW'(1);
            end
          end
          if (emit_ok) begin
            sum_nxt = '0;
            dy_nxt = -$signed({3'd0, half});
            state_nxt = S_ROWA;
          end
        end
      end
      S_ROWA: begin
        ry_nxt = RYW'(ry_s);
        state_nxt = S_ROWB;
      end
      S_ROWB: begin
        prod_nxt = (RYW+RCW)'(ry_r) * (RYW+RCW)'(RECIP);
        state_nxt = S_ROWC;
      end
      S_ROWC: begin
        slot_nxt = SLW'(rem_est);
        state_nxt = S_ROWD;
      end
      S_ROWD: begin
        base_nxt = AW'(slot_r) * AW'(MAX_WIDTH);
        dx_nxt = -$signed({3'd0, half});
        state_nxt = S_TAP;
      end
      S_TAP: begin
        rd_vld_nxt = 1'b1;
        dx_nxt = dx_r + 6'sd1;
        if (dx_r == $signed({3'd0, half})) begin
          if (dy_r == $signed({3'd0, half})) begin
            state_nxt = S_TAIL;
          end else begin
            dy_nxt = dy_r + 6'sd1;
            state_nxt = S_ROWA;
          end
        end
      end
      S_TAIL: begin
        state_nxt = S_DSET;
      end
      S_DSET: begin
        num_nxt = NUM_W'({sum_r, 1'b0}) + NUM_W'(kk);
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, den}) begin
          rem_nxt = DW'(rem_sh - {1'b0, den});
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = DW'(rem_sh);
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNTW'(1);
        if (32'(cnt_r) == NUM_W - 1) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.pixel_out = quo_r[7:0];
          out_data_nxt.last_of_frame = 1'b0;
          state_nxt = S_IDLE;
          if (32'(out_col_r) + 1 >= 32'(width_r)) begin
            out_col_nxt = '0;
            if (out_row_r + RW'(1) >= RW'(height_r)) begin
              out_data_nxt.last_of_frame = 1'b1;
              out_row_nxt = '0;
              in_row_nxt = '0;
              in_col_nxt = '0;
              in_slot_nxt = '0;
            end else begin
              out_row_nxt = out_row_r + RW'(1);
            end
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes restart the frame
    if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
                   cfg_index == CFG_KERNEL_SIZE)) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_data[10:0];
        CFG_IMAGE_HEIGHT: height_nxt = cfg_data[12:0];
        CFG_KERNEL_SIZE:  kern_nxt   = cfg_data[3:0];
        default:          kern_nxt   = kern_r;
      endcase
      in_row_nxt = '0;  in_col_nxt = '0;  in_slot_nxt = '0;
      out_row_nxt = '0;  out_col_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      kern_r <= KERNEL_RST;
      state_r <= S_IDLE;
      in_row_r <= '0;  in_col_r <= '0;  in_slot_r <= '0;
      out_row_r <= '0;  out_col_r <= '0;
      rd_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
      kern_r <= kern_nxt;
      state_r <= state_nxt;
      in_row_r <= in_row_nxt;  in_col_r <= in_col_nxt;  in_slot_r <= in_slot_nxt;
      out_row_r <= out_row_nxt;  out_col_r <= out_col_nxt;
      rd_vld_r <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;  dy_r <= dy_nxt;  dx_r <= dx_nxt;
    ry_r <= ry_nxt;  prod_r <= prod_nxt;  base_r <= base_nxt;
    sum_r <= sum_nxt;
    num_r <= num_nxt;  quo_r <= quo_nxt;  rem_r <= rem_nxt;  cnt_r <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- design/bbr_ram.sv -----
// ----------------------------------------------------------------------------
// bbr_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module bbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bbr_checker.sv -----
// ----------------------------------------------------------------------------
// bbr_checker
// port level checks of the box blur, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input bbr_pkg::out_req_t out_data
);
  import bbr_pkg::*;

  // a stalled result holds
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  // reset empties the output register
  `AST_NEXT_RST(a_rst_empty, clk, !rst_n, !out_valid)
  // a fresh result only follows a busy cycle
  `AST_NOW(a_rise_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind box_blur_reflect101 bbr_checker u_bbr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- tb/tb_box_blur_reflect101.sv -----
// ----------------------------------------------------------------------------
// tb_box_blur_reflect101
// self-checking bench for the reflect-101 box blur
// ----------------------------------------------------------------------------
// Frames of pixel and flush requests are queued by the stimulus block and fed
// to the block with random gaps. Each accepted request updates a local model
// of the line store and raster counters, which queues the expected means.
// Results are checked in order against that queue. Invalid setups, early
// flushes, surplus pixels and partial frames are mixed in with valid frames.
// ----------------------------------------------------------------------------
module tb_box_blur_reflect101;
  import bbr_pkg::*;

  localparam int ROW_W      = 1024;
  localparam int ROWS_KEPT  = 16;
  localparam int KMAX       = 15;
  localparam int DRAIN_WAIT = 500;
  localparam int CYCLE_CAP  = 3000000;
  // register index with no register behind it
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_reflect101 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_req_t  pixel_req_q[$];
  out_req_t mean_q[$];
  int errors = 0;
  int means_seen = 0;
  int reqs_taken = 0;
  int frames_done = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  bit held_off = 1'b0;

  // local copy of the blur state
  logic [7:0] pix_store [0:ROWS_KEPT*ROW_W-1];
  int unsigned img_w, img_h, ksz;
  int unsigned irow, icol, orow, ocol;

  task automatic report(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d want %0d", means_seen, what, got, want);
    errors++;
  endtask

  function automatic bit setup_ok();
    int unsigned h;
    h = ksz / 2;
    if (ksz == 0 || ksz[0] == 1'b0 || ksz > KMAX) return 1'b0;
    if (img_w < h + 2 || img_w > ROW_W) return 1'b0;
    if (img_h < h + 2 || img_h > MAX_HEIGHT) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int fold(int i, int n);
    int j;
    j = (i < 0) ? -i : i;
    if (j >= n) j = 2 * (n - 1) - j;
    if (j < 0 || j >= n) j = 0;
    return j;
  endfunction

  // expected mean at the current output position, then advance it
  function automatic void emit_mean();
    int h;
    int ry;
    int unsigned sum, kk, v;
    logic last;
    h = ksz / 2;
    sum = 0;
    kk = ksz * ksz;
    for (int dy = -h; dy <= h; dy++) begin
      ry = fold(int'(orow) + dy, img_h);
      for (int dx = -h; dx <= h; dx++)
        sum += pix_store[(ry % ROWS_KEPT) * ROW_W + fold(int'(ocol) + dx, img_w)];
    end
    v = (2 * sum + kk) / (2 * kk);
    last = 1'b0;
    ocol++;
    if (ocol >= img_w) begin
      ocol = 0;
      orow++;
      if (orow >= img_h) begin
        last = 1'b1;
        irow = 0; icol = 0; orow = 0; ocol = 0;
      end
    end
    mean_q.push_back('{pixel_out: v[7:0], last_of_frame: last});
  endfunction

  function automatic void blur_predict(in_req_t rq);
    bit fire;
    if (!setup_ok()) return;
    if (rq.operation == OP_FLUSH) begin
      if (irow >= img_h && orow < img_h) emit_mean();
      return;
    end
    if (irow >= img_h) return;
    pix_store[(irow % ROWS_KEPT) * ROW_W + icol] = rq.pixel_in;
    fire = (irow >= ksz / 2 + 1);
    icol++;
    if (icol >= img_w) begin
      icol = 0;
      irow++;
    end
    if (fire) emit_mean();
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // register writes as seen by the block
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w = cfg_data[10:0];
        CFG_IMAGE_HEIGHT: img_h = cfg_data[12:0];
        CFG_KERNEL_SIZE:  ksz = cfg_data[3:0];
        default: ;
      endcase
      if (cfg_index != CFG_UNMAPPED) begin
        irow = 0; icol = 0; orow = 0; ocol = 0;
      end
    end
  end

  // request driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        blur_predict(in_data);
        reqs_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pixel_req_q.size() > 0) begin
        in_data <= pixel_req_q.pop_front();
        in_valid <= 1'b1;
        send_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (mean_q.size() == 0) begin
          report("unexpected result, pixel_out", out_data.pixel_out, -1);
        end else begin
          want = mean_q.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report("pixel_out", out_data.pixel_out, want.pixel_out);
          if (out_data.last_of_frame !== want.last_of_frame)
            report("last_of_frame", out_data.last_of_frame, want.last_of_frame);
          if (want.last_of_frame) frames_done++;
        end
        means_seen++;
      end
      // one long hold-off so the block backs up into its input
      if (!held_off && means_seen == 120) begin
        held_off = 1'b1;
        stall_left = 1500;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 9) < 3) begin
        stall_left = gap_len();
      end
      out_stall <= (stall_left != 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // junk in the unused upper bits of the narrow registers
  task automatic set_dims(int w, int h, int k);
    cfg_write(CFG_IMAGE_WIDTH, {2'($urandom), 11'(w)});
    cfg_write(CFG_IMAGE_HEIGHT, 13'(h));
    cfg_write(CFG_KERNEL_SIZE, {9'($urandom), 4'(k)});
  endtask

  task automatic wait_idle();
    while (pixel_req_q.size() > 0 || in_valid || mean_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic void push_req(logic op, logic [7:0] px);
    pixel_req_q.push_back('{operation: op, pixel_in: px});
  endfunction

  // one frame with an early flush, a surplus pixel and trailing flushes, or only
  // its first stop_at pixels; returns how many requests count as real work
  function automatic int push_frame(int w, int h, int k, int stop_at);
    int n;
    n = 0;
    push_req(OP_FLUSH, 8'($urandom));
    for (int i = 0; i < w * h && i < stop_at; i++) begin
      push_req(OP_PIXEL, 8'($urandom));
      n++;
    end
    if (stop_at < w * h) return n;
    push_req(OP_PIXEL, 8'($urandom));
    for (int i = 0; i < (k / 2 + 1) * w + 2; i++) begin
      push_req(OP_FLUSH, 8'($urandom));
      n++;
    end
    return n;
  endfunction

  initial begin
    int work;
    int k, w, h, pick;
    int ks[13] = '{1, 3, 3, 3, 5, 5, 7, 9, 11, 13, 15, 2, 0};
    for (int i = 0; i < ROWS_KEPT * ROW_W; i++) pix_store[i] = 8'd0;
    img_w = WIDTH_RST; img_h = HEIGHT_RST; ksz = KERNEL_RST;
    irow = 0; icol = 0; orow = 0; ocol = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset setup takes pixels but is far from any output
    push_req(OP_PIXEL, 8'd0);
    push_req(OP_FLUSH, 8'd255);
    wait_idle();

    // smallest frame with extreme pixels, unmapped index write mid-frame
    set_dims(3, 3, 3);
    for (int i = 0; i < 4; i++) push_req(OP_PIXEL, i[0] ? 8'd255 : 8'd0);
    wait_idle();
    cfg_write(CFG_UNMAPPED, 13'h1fff);
    for (int i = 0; i < 5; i++) push_req(OP_PIXEL, i[0] ? 8'd0 : 8'd255);
    push_req(OP_PIXEL, 8'd7);
    for (int i = 0; i < 8; i++) push_req(OP_FLUSH, 8'd0);
    wait_idle();

    // invalid setups: every request ignored
    set_dims(3, 3, 4);
    push_req(OP_PIXEL, 8'd1); push_req(OP_FLUSH, 8'd0);
    wait_idle();
    set_dims(3, 3, 0);
    push_req(OP_PIXEL, 8'd2);
    wait_idle();
    set_dims(2047, 3, 3);
    push_req(OP_PIXEL, 8'd3);
    wait_idle();
    set_dims(5, 8191, 3);
    push_req(OP_PIXEL, 8'd4);
    wait_idle();
    set_dims(2, 5, 3);
    push_req(OP_PIXEL, 8'd5);
    wait_idle();

    // extreme valid sizes, a partial frame at the largest, a full one at the smallest
    set_dims(1024, 4096, 15);
    work = push_frame(1024, 4096, 15, 30);
    wait_idle();
    set_dims(3, 3, 1);
    work = push_frame(3, 3, 1, 9);
    wait_idle();

    // random phases
    work = 0;
    while (work < 650) begin
      pick = $urandom_range(0, 12);
      k = ks[pick];
      no_gaps = ($urandom_range(0, 3) == 0);
      if (k >= 9) begin
        w = k / 2 + 2 + $urandom_range(0, 1);
        h = k / 2 + 2 + $urandom_range(0, 1);
      end else begin
        w = k / 2 + 2 + $urandom_range(0, 8);
        h = k / 2 + 2 + $urandom_range(0, 6);
        if (w < 3) w = 3;
        if (h < 3) h = 3;
      end
      set_dims(w, h, k);
      if (k == 0 || k[0] == 1'b0) begin
        for (int i = 0; i < 4; i++) push_req(1'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 4) == 0) begin
        work += push_frame(w, h, k, $urandom_range(1, w * h - 1));
      end else begin
        work += push_frame(w, h, k, w * h);
      end
      wait_idle();
    end

    $display("%0d requests taken, %0d means checked over %0d full frames",
             reqs_taken, means_seen, frames_done);
    $display("kernels 1 to 15, invalid setups, flush and surplus pixel cases covered");
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/bbr_pkg.sv
design/bbr_ram.sv
design/box_blur_reflect101.sv
design/bbr_checker.sv
tb/tb_box_blur_reflect101.sv
